### hdl/vtv_pkg.sv
package vtv_pkg;

    // coordinate format
    localparam int COORD_BITS  = 16;
    localparam int COORD_FRAC  = COORD_BITS / 2;
    localparam int NDC_FRAC    = 16;
    localparam int CAP_BITS    = 20;
    // dot product width and magnitude width
    localparam int DOT_W       = 34;
    localparam int MAG_W       = 33;
    // quotient carries one extra fraction bit for rounding
    localparam int QUO_W       = CAP_BITS + NDC_FRAC + 1;
    localparam int DIV_PER_STG = 4;
    localparam int DIV_STAGES  = (QUO_W + DIV_PER_STG - 1) / DIV_PER_STG;
    localparam int SIZE_W      = 13;
    localparam int CFG_IDX_W   = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW0   = 3'd0,
        CFG_ROW1   = 3'd1,
        CFG_ROW2   = 3'd2,
        CFG_ROW3   = 3'd3,
        CFG_WIDTH  = 3'd4,
        CFG_HEIGHT = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] in_x;
        logic signed [COORD_BITS-1:0] in_y;
        logic signed [COORD_BITS-1:0] in_z;
        logic [15:0]                  in_u;
        logic [15:0]                  in_v;
        logic                         in_last;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] screen_x;
        logic signed [15:0] screen_y;
        logic signed [15:0] depth;
        logic [15:0]        out_u;
        logic [15:0]        out_v;
        logic               w_zero;
        logic               clipped;
        logic               out_last;
    } t_out_word;

    // one lane of the long divider
    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [QUO_W-1:0] dvd;
        logic [QUO_W-1:0] quo;
        logic             neg;
        logic             cap;
        logic             nneg;
    } t_div_lane;

    // data that rides along the divider
    typedef struct packed {
        logic [15:0]      u;
        logic [15:0]      v;
        logic             last;
        logic             wz;
        logic [MAG_W-1:0] den;
    } t_side;

endpackage

### hdl/vertex_transform_viewport_top.sv
// Vertex transform, perspective divide and viewport mapping.
// Input channel: i_in_valid / o_in_stall carrying one vertex word (t_in_word).
// A word is taken at a clock edge with i_in_valid high and o_in_stall low.
// Output channel: o_out_valid / i_out_stall carrying one screen word
// (t_out_word); one output word per input word, in order.
// Config channel: i_cfg_valid / o_cfg_ready (always ready), index 0..3 are the
// matrix rows, 4 width, 5 height; other indexes are ignored. Write it only
// while the pipe is empty.
// The pipe has 16 register stages. Throughput is one word per cycle while
// the receiver does not stall; the 37-bit restoring divider is split over
// 10 stages of up to 4 steps each, so a new word can enter the divider
// while earlier words are still being divided.
// Reset (i_rst_n low, synchronous) empties the pipe and loads the identity
// matrix with a 640 x 480 viewport.
// When the receiver stalls with a word waiting, the whole pipe freezes and
// o_in_stall goes high the same cycle; nothing is lost or repeated.
module vertex_transform_viewport_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  vtv_pkg::t_in_word         i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output vtv_pkg::t_out_word        o_out_data,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [vtv_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]               i_cfg_data
);
    import vtv_pkg::*;

    // config registers
    logic [63:0]       r_mat [4];
    logic [SIZE_W-1:0] r_width, r_height;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat[0] <= 64'h0000_0000_0000_1000;
            r_mat[1] <= 64'h0000_0000_1000_0000;
            r_mat[2] <= 64'h0000_1000_0000_0000;
            r_mat[3] <= 64'h1000_0000_0000_0000;
            r_width  <= SIZE_W'(640);
            r_height <= SIZE_W'(480);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ROW0:   r_mat[0] <= i_cfg_data;
                CFG_ROW1:   r_mat[1] <= i_cfg_data;
                CFG_ROW2:   r_mat[2] <= i_cfg_data;
                CFG_ROW3:   r_mat[3] <= i_cfg_data;
                CFG_WIDTH:  r_width  <= i_cfg_data[SIZE_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // global advance: freeze only when a finished word is held
    logic en;
    logic r_out_valid;
    assign en         = !(r_out_valid && i_out_stall);
    assign o_in_stall = !en;

    // ---------------- stage 1: products ----------------
    logic               r1_valid;
    logic signed [31:0] r1_prod [4][3];
    logic signed [15:0] r1_wcoef [4];
    logic [15:0]        r1_u, r1_v;
    logic               r1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < 4; r++) begin
                r1_prod[r][0] <= $signed(r_mat[r][15:0])  * i_in_data.in_x;
                r1_prod[r][1] <= $signed(r_mat[r][31:16]) * i_in_data.in_y;
                r1_prod[r][2] <= $signed(r_mat[r][47:32]) * i_in_data.in_z;
                r1_wcoef[r]   <= $signed(r_mat[r][63:48]);
            end
            r1_u    <= i_in_data.in_u;
            r1_v    <= i_in_data.in_v;
            r1_last <= i_in_data.in_last;
        end
    end

    // ---------------- stage 2: dot sums ----------------
    logic                  r2_valid;
    logic signed [DOT_W-1:0] r2_dot [4];
    logic [15:0]           r2_u, r2_v;
    logic                  r2_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < 4; r++) begin
                r2_dot[r] <= DOT_W'(r1_prod[r][0]) + DOT_W'(r1_prod[r][1])
                           + DOT_W'(r1_prod[r][2])
                           + (DOT_W'(r1_wcoef[r]) <<< COORD_FRAC);
            end
            r2_u    <= r1_u;
            r2_v    <= r1_v;
            r2_last <= r1_last;
        end
    end

    // ---------------- stage 3: divider setup ----------------
    t_div_lane r_dl [DIV_STAGES+1][3];
    t_side     r_ds [DIV_STAGES+1];
    logic      r_dv [DIV_STAGES+1];

    t_div_lane n_lane0 [3];
    t_side     n_side0;

    always_comb begin
        logic [DOT_W-1:0] wabs;
        logic [DOT_W-1:0] nabs;
        wabs = r2_dot[3][DOT_W-1] ? DOT_W'(-r2_dot[3]) : DOT_W'(r2_dot[3]);
        n_side0.u    = r2_u;
        n_side0.v    = r2_v;
        n_side0.last = r2_last;
        n_side0.wz   = (r2_dot[3] == '0);
        n_side0.den  = wabs[MAG_W-1:0];
        for (int l = 0; l < 3; l++) begin
            nabs = r2_dot[l][DOT_W-1] ? DOT_W'(-r2_dot[l]) : DOT_W'(r2_dot[l]);
            n_lane0[l].nneg = r2_dot[l][DOT_W-1];
            n_lane0[l].neg  = r2_dot[l][DOT_W-1] ^ r2_dot[3][DOT_W-1];
            n_lane0[l].rem  = MAG_W'(nabs[MAG_W-1:CAP_BITS]);
            n_lane0[l].cap  = MAG_W'(nabs[MAG_W-1:CAP_BITS]) >= wabs[MAG_W-1:0];
            n_lane0[l].dvd  = {nabs[CAP_BITS-1:0], (NDC_FRAC+1)'(0)};
            n_lane0[l].quo  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ds[0] <= n_side0;
            for (int l = 0; l < 3; l++) begin
                r_dl[0][l] <= n_lane0[l];
            end
        end
    end

    // ---------------- divider stages ----------------
    for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_div
        t_div_lane n_lane [3];

        // restoring steps; steps past the quotient width pass through
        always_comb begin
            logic [MAG_W:0] t;
            for (int l = 0; l < 3; l++) begin
                n_lane[l] = r_dl[s-1][l];
                for (int j = 0; j < DIV_PER_STG; j++) begin
                    if ((s - 1) * DIV_PER_STG + j < QUO_W) begin
                        t = {n_lane[l].rem, n_lane[l].dvd[QUO_W-1]};
                        n_lane[l].dvd = {n_lane[l].dvd[QUO_W-2:0], 1'b0};
                        if (t >= {1'b0, r_ds[s-1].den}) begin
                            n_lane[l].rem = MAG_W'(t - {1'b0, r_ds[s-1].den});
                            n_lane[l].quo = {n_lane[l].quo[QUO_W-2:0], 1'b1};
                        end else begin
                            n_lane[l].rem = t[MAG_W-1:0];
                            n_lane[l].quo = {n_lane[l].quo[QUO_W-2:0], 1'b0};
                        end
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[s] <= 1'b0;
            end else if (en) begin
                r_dv[s] <= r_dv[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_ds[s] <= r_ds[s-1];
                for (int l = 0; l < 3; l++) begin
                    r_dl[s][l] <= n_lane[l];
                end
            end
        end
    end

    // ---------------- post: round quotient, depth ----------------
    localparam int CLAMP_W = 31;
    logic                r_p_valid;
    logic signed [32:0]  r_p_ndcp [2];
    logic signed [15:0]  r_p_depth;
    logic                r_p_satz;
    logic [2:0]          r_p_nneg;
    t_side               r_p_side;

    logic signed [32:0]  n_ndcp [2];
    logic signed [15:0]  n_depth;
    logic                n_satz;

    always_comb begin
        logic [QUO_W-1:0]   qmag;
        logic [CLAMP_W-1:0] cm;
        logic [QUO_W-1:0]   dsum;
        logic [QUO_W-9:0]   dmag;
        n_depth = '0;
        n_satz  = 1'b0;
        for (int l = 0; l < 3; l++) begin
            qmag = r_dl[DIV_STAGES][l].cap ? (QUO_W'(1) << (QUO_W - 1))
                 : QUO_W'(({1'b0, r_dl[DIV_STAGES][l].quo} + (QUO_W+1)'(1)) >> 1);
            if (l < 2) begin
                // beyond 2^30 every nonzero size saturates anyway
                cm = (qmag > QUO_W'(1 << 30)) ? CLAMP_W'(1 << 30) : qmag[CLAMP_W-1:0];
                n_ndcp[l] = (r_dl[DIV_STAGES][l].neg ? -$signed({2'b0, cm})
                                                     : $signed({2'b0, cm}))
                          + 33'sd65536;
            end else begin
                dsum = qmag + QUO_W'(128);
                dmag = dsum[QUO_W-1:8];
                if (r_dl[DIV_STAGES][l].neg) begin
                    n_satz  = dmag > (QUO_W-8)'(32768);
                    n_depth = n_satz ? -16'sd32768 : 16'(-dmag[15:0]);
                end else begin
                    n_satz  = dmag > (QUO_W-8)'(32767);
                    n_depth = n_satz ? 16'sd32767 : $signed(dmag[15:0]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (en) begin
            r_p_valid <= r_dv[DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_ndcp  <= n_ndcp;
            r_p_depth <= n_depth;
            r_p_satz  <= n_satz;
            r_p_side  <= r_ds[DIV_STAGES];
            for (int l = 0; l < 3; l++) begin
                r_p_nneg[l] <= r_dl[DIV_STAGES][l].nneg;
            end
        end
    end

    // ---------------- viewport multiply ----------------
    logic                r_m_valid;
    logic signed [46:0]  r_m_prod [2];
    logic signed [15:0]  r_m_depth;
    logic                r_m_satz;
    logic [2:0]          r_m_nneg;
    t_side               r_m_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (en) begin
            r_m_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_prod[0] <= r_p_ndcp[0] * $signed({1'b0, r_width});
            r_m_prod[1] <= r_p_ndcp[1] * $signed({1'b0, r_height});
            r_m_depth   <= r_p_depth;
            r_m_satz    <= r_p_satz;
            r_m_nneg    <= r_p_nneg;
            r_m_side    <= r_p_side;
        end
    end

    // ---------------- output: round to Q12.4, saturate ----------------
    localparam int SHIFT = NDC_FRAC + 1 - 4;
    logic signed [15:0] n_scr [2];
    logic [1:0]         n_sat;
    t_out_word          n_out;
    t_out_word          r_out;

    always_comb begin
        logic [46:0] tmag;
        logic [46:0] tsum;
        logic [46-SHIFT:0] rmag;
        for (int l = 0; l < 2; l++) begin
            tmag = r_m_prod[l][46] ? 47'(-r_m_prod[l]) : 47'(r_m_prod[l]);
            tsum = tmag + 47'(1 << (SHIFT - 1));
            rmag = tsum[46:SHIFT];
            if (r_m_prod[l][46]) begin
                n_sat[l] = rmag > (47-SHIFT)'(32768);
                n_scr[l] = n_sat[l] ? -16'sd32768 : 16'(-rmag[15:0]);
            end else begin
                n_sat[l] = rmag > (47-SHIFT)'(32767);
                n_scr[l] = n_sat[l] ? 16'sd32767 : $signed(rmag[15:0]);
            end
        end
        n_out.out_u    = r_m_side.u;
        n_out.out_v    = r_m_side.v;
        n_out.out_last = r_m_side.last;
        n_out.w_zero   = r_m_side.wz;
        if (r_m_side.wz) begin
            n_out.screen_x = r_m_nneg[0] ? -16'sd32768 : 16'sd32767;
            n_out.screen_y = r_m_nneg[1] ? -16'sd32768 : 16'sd32767;
            n_out.depth    = r_m_nneg[2] ? -16'sd32768 : 16'sd32767;
            n_out.clipped  = 1'b1;
        end else begin
            n_out.screen_x = n_scr[0];
            n_out.screen_y = n_scr[1];
            n_out.depth    = r_m_depth;
            n_out.clipped  = n_sat[0] | n_sat[1] | r_m_satz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---------------- checks ----------------
    a_wz_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.w_zero |-> o_out_data.clipped)
        else $error("w_zero without clipped");

    a_wz_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.w_zero |->
            (o_out_data.screen_x == 16'sd32767 || o_out_data.screen_x == -16'sd32768))
        else $error("zero w result not saturated");

    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> r1_valid)
        else $error("accepted word lost at entry");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> $stable(r_dv[DIV_STAGES]) && $stable(r_m_valid))
        else $error("pipe moved while frozen");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !r_m_valid)
        else $error("pipe not empty after reset");

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import vtv_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_word    i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_word   o_out_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [63:0] i_cfg_data;

    vertex_transform_viewport_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // shadow copy of the configuration
    logic [63:0] mat_row [4];
    logic [12:0] vp_width;
    logic [12:0] vp_height;

    t_in_word  vertex_q [$];
    t_out_word screen_q [$];
    int        mismatch_cnt = 0;
    int        unexpected_cnt = 0;
    bit        hold_sender;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // round to nearest, ties away from zero
    function automatic longint round_shift(longint v, int s);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (64'sd1 <<< (s - 1))) >>> s;
        return (v < 0) ? -mag : mag;
    endfunction

    // ratio in Q.16, magnitude capped at 2^20
    function automatic longint ratio_q16(longint num, longint den);
        longint unsigned n, d, ip, r, f, q;
        bit neg;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        ip = n / d;
        r = n % d;
        f = 0;
        if (ip >= (64'd1 << 20)) begin
            q = 64'd1 << 36;
        end else begin
            for (int i = 0; i < 17; i++) begin
                r = r << 1;
                f = f << 1;
                if (r >= d) begin
                    r = r - d;
                    f = f | 1;
                end
            end
            q = ((ip << 17) | f);
            q = (q + 1) >> 1;
        end
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clamp16(longint v, ref bit sat);
        if (v > 32767) begin
            sat = 1'b1;
            return 32767;
        end
        if (v < -32768) begin
            sat = 1'b1;
            return -32768;
        end
        return v;
    endfunction

    function automatic t_out_word project_vertex(t_in_word vin);
        longint    vec [4];
        longint    acc [4];
        longint    sx, sy, dz;
        bit        sat;
        t_out_word res;
        vec[0] = longint'(vin.in_x);
        vec[1] = longint'(vin.in_y);
        vec[2] = longint'(vin.in_z);
        vec[3] = 256;
        sat = 1'b0;
        for (int r = 0; r < 4; r++) begin
            acc[r] = 0;
            for (int c = 0; c < 4; c++)
                acc[r] += longint'($signed(mat_row[r][16*c +: 16])) * vec[c];
        end
        if (acc[3] == 0) begin
            sx = (acc[0] < 0) ? -32768 : 32767;
            sy = (acc[1] < 0) ? -32768 : 32767;
            dz = (acc[2] < 0) ? -32768 : 32767;
            sat = 1'b1;
        end else begin
            sx = clamp16(round_shift((ratio_q16(acc[0], acc[3]) + 65536) *
                longint'(vp_width), 13), sat);
            sy = clamp16(round_shift((ratio_q16(acc[1], acc[3]) + 65536) *
                longint'(vp_height), 13), sat);
            dz = clamp16(round_shift(ratio_q16(acc[2], acc[3]), 8), sat);
        end
        res.screen_x = sx[15:0];
        res.screen_y = sy[15:0];
        res.depth    = dz[15:0];
        res.out_u    = vin.in_u;
        res.out_v    = vin.in_v;
        res.w_zero   = (acc[3] == 0);
        res.clipped  = sat;
        res.out_last = vin.in_last;
        return res;
    endfunction

    // driver: bursts with random gaps; prediction at acceptance
    int burst_left;
    int gap_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            automatic bit sent = i_in_valid && !o_in_stall;
            automatic bit busy = i_in_valid && !sent;
            if (sent) begin
                screen_q.push_back(project_vertex(i_in_data));
                void'(vertex_q.pop_front());
            end
            if (!busy) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (vertex_q.size() > 0 && !hold_sender) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= vertex_q[0];
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 30);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern: quiet stretches and busy stretches
    int stall_phase;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_phase <= 0;
        end else begin
            stall_phase <= (stall_phase + 1) % 200;
            if (stall_phase < 60)
                i_out_stall <= 1'b0;
            else
                i_out_stall <= ($urandom_range(0, 2) == 0);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (screen_q.size() == 0) begin
                unexpected_cnt++;
                if (unexpected_cnt + mismatch_cnt <= 10)
                    $display("unexpected word %h", o_out_data);
            end else begin
                automatic t_out_word exp_w = screen_q.pop_front();
                if (exp_w !== o_out_data) begin
                    mismatch_cnt++;
                    if (mismatch_cnt + unexpected_cnt <= 10)
                        $display("mismatch: exp x=%0d y=%0d z=%0d u=%h v=%h wz=%b c=%b l=%b  got x=%0d y=%0d z=%0d u=%h v=%h wz=%b c=%b l=%b",
                            exp_w.screen_x, exp_w.screen_y, exp_w.depth, exp_w.out_u,
                            exp_w.out_v, exp_w.w_zero, exp_w.clipped, exp_w.out_last,
                            o_out_data.screen_x, o_out_data.screen_y, o_out_data.depth,
                            o_out_data.out_u, o_out_data.out_v, o_out_data.w_zero,
                            o_out_data.clipped, o_out_data.out_last);
                end
            end
        end
    end

    // config write: one word, shadow updated on acceptance
    task automatic write_reg(t_cfg_idx idx, logic [63:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_ROW0:   mat_row[0] = val;
            CFG_ROW1:   mat_row[1] = val;
            CFG_ROW2:   mat_row[2] = val;
            CFG_ROW3:   mat_row[3] = val;
            CFG_WIDTH:  vp_width   = val[12:0];
            CFG_HEIGHT: vp_height  = val[12:0];
            default: ;
        endcase
    endtask

    task automatic drain_pipe();
        while (vertex_q.size() > 0 || screen_q.size() > 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);
    endtask

    function automatic t_in_word rand_vertex(bit smallish);
        t_in_word    v;
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        v = raw[$bits(t_in_word)-1:0];
        if (smallish) begin
            v.in_x = 16'($signed($urandom_range(0, 1023)) - 512);
            v.in_y = 16'($signed($urandom_range(0, 1023)) - 512);
            v.in_z = 16'($signed($urandom_range(0, 1023)) - 512);
        end
        return v;
    endfunction

    function automatic logic [63:0] rand_row(bit tame);
        logic [63:0] r;
        r = {$urandom, $urandom};
        if (tame)
            for (int c = 0; c < 4; c++)
                r[16*c +: 16] = 16'($signed($urandom_range(0, 8192)) - 4096);
        return r;
    endfunction

    // random phase: random vertices, mostly with small coordinates when tame
    task automatic random_phase(int n, bit tame);
        for (int i = 0; i < n; i++)
            vertex_q.push_back(rand_vertex(tame && ($urandom_range(0, 3) != 0)));
        drain_pipe();
    endtask

    initial begin
        t_in_word    v;
        logic [63:0] row3;
        hold_sender    = 1'b0;
        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        mat_row[0] = 64'd4096;
        mat_row[1] = 64'd268435456;
        mat_row[2] = 64'd17592186044416;
        mat_row[3] = 64'd1152921504606846976;
        vp_width   = 13'd640;
        vp_height  = 13'd480;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes under reset identity
        v = '0;                                              vertex_q.push_back(v);
        v = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'hffff, 16'hffff, 1'b1};
        vertex_q.push_back(v);
        v = '{16'sh8000, 16'sh8000, 16'sh8000, 16'h0000, 16'h0000, 1'b0};
        vertex_q.push_back(v);
        v = '{16'sh0100, 16'shff00, 16'sh0080, 16'h5555, 16'haaaa, 1'b1};
        vertex_q.push_back(v);
        v = '{16'shff00, 16'sh0100, -16'sh0080, 16'haaaa, 16'h5555, 1'b0};
        vertex_q.push_back(v);
        // let part of the group go, then hold the sender until all results are back
        while (vertex_q.size() > 2) @(posedge i_clk);
        hold_sender = 1'b1;
        while (screen_q.size() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        hold_sender = 1'b0;
        drain_pipe();

        // zero w: row 3 all zero, numerators of both signs
        write_reg(CFG_ROW3, 64'h0);
        v = '{16'sh0100, -16'sh0100, 16'sh0000, 16'h1234, 16'h4321, 1'b0};
        vertex_q.push_back(v);
        v = '{-16'sh0100, 16'sh0100, -16'sh0001, 16'h1, 16'h2, 1'b1};
        vertex_q.push_back(v);
        drain_pipe();

        // divide overflow: tiny w, and w = z for a real projection
        write_reg(CFG_ROW3, 64'h0000_0000_0000_0001);
        v = '{16'sh7fff, -16'sh7fff, 16'sh0100, 16'h0, 16'h0, 1'b0};
        vertex_q.push_back(v);
        drain_pipe();
        write_reg(CFG_ROW3, {16'h0000, 16'h1000, 16'h0000, 16'h0000});
        v = '{16'sh0100, 16'sh0080, 16'sh0200, 16'h0, 16'h0, 1'b0};
        vertex_q.push_back(v);
        v = '{16'sh0100, 16'sh0080, -16'sh0200, 16'h0, 16'h0, 1'b1};
        vertex_q.push_back(v);
        v = '{16'sh0100, 16'sh0080, 16'sh0000, 16'h0, 16'h0, 1'b0};
        vertex_q.push_back(v);
        drain_pipe();

        // viewport extremes: zero, one, max 13-bit
        write_reg(CFG_WIDTH, 64'd0);
        write_reg(CFG_HEIGHT, 64'h1fff);
        random_phase(8, 1'b1);
        write_reg(CFG_WIDTH, 64'd1);
        write_reg(CFG_HEIGHT, 64'd4096);
        random_phase(8, 1'b1);
        // extreme coefficients
        write_reg(CFG_ROW0, 64'h7fff_8000_7fff_8000);
        write_reg(CFG_ROW1, 64'h8000_7fff_8000_7fff);
        write_reg(CFG_ROW2, 64'hffff_ffff_ffff_ffff);
        write_reg(CFG_ROW3, 64'h7fff_7fff_7fff_7fff);
        random_phase(8, 1'b0);

        // random phases over several settings
        for (int p = 0; p < 8; p++) begin
            automatic bit tame = (p % 4) != 3;
            write_reg(CFG_ROW0, rand_row(tame));
            write_reg(CFG_ROW1, rand_row(tame));
            write_reg(CFG_ROW2, rand_row(tame));
            if (tame) begin
                row3 = rand_row(1'b1);
                row3[15:0] = 16'(12'($urandom)) + 16'h0800;
                write_reg(CFG_ROW3, row3);
            end else begin
                write_reg(CFG_ROW3, rand_row(1'b0));
            end
            write_reg(CFG_WIDTH, 64'($urandom_range(1, 4096)));
            write_reg(CFG_HEIGHT, 64'($urandom_range(0, 8191)));
            random_phase(48, tame);
        end

        if (mismatch_cnt == 0 && unexpected_cnt == 0 && screen_q.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        #4000000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule

### filelist.f
hdl/vtv_pkg.sv
hdl/vertex_transform_viewport_top.sv
verif/tb_top.sv
